// ----- rtl/pcsc_pkg.sv -----
// Shared types, codes and constants of the PNG chunk stream checker.
package pcsc_pkg;

   // Walk phases
   localparam logic [2:0] PH_SIG       = 3'd0;
   localparam logic [2:0] PH_IHDR_LEN  = 3'd1;
   localparam logic [2:0] PH_IHDR_TYPE = 3'd2;
   localparam logic [2:0] PH_LEN       = 3'd3;
   localparam logic [2:0] PH_TYPE      = 3'd4;
   localparam logic [2:0] PH_DATA      = 3'd5;
   localparam logic [2:0] PH_CRC       = 3'd6;
   localparam logic [2:0] PH_DONE      = 3'd7;

   // Result status codes
   localparam logic [3:0] ST_SIG_GOOD     = 4'd0;
   localparam logic [3:0] ST_SIG_BAD      = 4'd1;
   localparam logic [3:0] ST_IHDR_GOOD    = 4'd2;
   localparam logic [3:0] ST_IHDR_BAD     = 4'd3;
   localparam logic [3:0] ST_IDAT         = 4'd4;
   localparam logic [3:0] ST_IEND_FOUND   = 4'd5;
   localparam logic [3:0] ST_NO_IDAT      = 4'd6;
   localparam logic [3:0] ST_IEND_MISSING = 4'd7;
   localparam logic [3:0] ST_TRUNCATED    = 4'd8;

   // Chunk type words, big-endian ASCII
   localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
   localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
   localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

   // Result queue
   localparam int RES_DEPTH = 4;
   localparam int RES_PTR_W = $clog2(RES_DEPTH);
   localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

   typedef struct packed {
      logic [3:0]  status;
      logic [31:0] chunk_offset;
      logic [31:0] chunk_length;
      logic [31:0] chunk_crc;
      logic        last_of_run;
   } result_type;

   // Up to two results written per byte; second only with the first
   typedef struct packed {
      logic       push0;
      logic       push1;
      result_type res0;
      result_type res1;
   } push_type;

   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0:    b = 8'd137;
         3'd1:    b = 8'd80;
         3'd2:    b = 8'd78;
         3'd3:    b = 8'd71;
         3'd4:    b = 8'd13;
         3'd5:    b = 8'd10;
         3'd6:    b = 8'd26;
         3'd7:    b = 8'd10;
         default: b = 8'd0;
      endcase
      return b;
   endfunction

   function automatic result_type mk_result(input logic [3:0] status);
      result_type r;
      r.status       = status;
      r.chunk_offset = '0;
      r.chunk_length = '0;
      r.chunk_crc    = '0;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

endpackage

// ----- rtl/pcsc_parser.sv -----
// Chunk walk state and per-byte result generation.
module pcsc_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  logic [7:0]         item_byte,
   input  logic               item_eos,
   output pcsc_pkg::push_type push
);

   logic [2:0]  phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] off_ff, off_in;
   logic [31:0] skip_ff, skip_in;
   logic        is_idat_ff, is_idat_in;
   logic        is_iend_ff, is_iend_in;
   logic        seen_idat_ff, seen_idat_in;
   logic        seen_other_ff, seen_other_in;
   logic        mismatch_ff, mismatch_in;

   logic [31:0] word;
   logic [31:0] skip_dec;
   logic        m_v, a_v, b_v;
   pcsc_pkg::result_type m_res, a_res, b_res;

   always_comb begin
      word     = {acc_ff[23:0], item_byte};
      skip_dec = skip_ff - 32'd1;

      phase_in      = phase_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      len_in        = len_ff;
      off_in        = off_ff;
      skip_in       = skip_ff;
      is_idat_in    = is_idat_ff;
      is_iend_in    = is_iend_ff;
      seen_idat_in  = seen_idat_ff;
      seen_other_in = seen_other_ff;
      mismatch_in   = mismatch_ff;

      m_v   = 1'b0;
      m_res = pcsc_pkg::mk_result(pcsc_pkg::ST_SIG_GOOD);
      a_v   = 1'b0;
      a_res = pcsc_pkg::mk_result(pcsc_pkg::ST_TRUNCATED);
      b_v   = 1'b0;
      b_res = pcsc_pkg::mk_result(pcsc_pkg::ST_IEND_MISSING);

      if (item_valid) begin
         unique case (phase_ff)
            pcsc_pkg::PH_SIG: begin
               mismatch_in = mismatch_ff | (item_byte != pcsc_pkg::sig_byte(cnt_ff));
               cnt_in      = cnt_ff + 3'd1;
               if (cnt_ff == 3'd7) begin
                  m_v   = 1'b1;
                  m_res = pcsc_pkg::mk_result(mismatch_in ? pcsc_pkg::ST_SIG_BAD
                                                          : pcsc_pkg::ST_SIG_GOOD);
                  phase_in = mismatch_in ? pcsc_pkg::PH_DONE : pcsc_pkg::PH_IHDR_LEN;
               end
            end
            pcsc_pkg::PH_IHDR_LEN, pcsc_pkg::PH_LEN: begin
               if (phase_ff == pcsc_pkg::PH_LEN && cnt_ff == 3'd0) begin
                  off_in = pos_ff;
               end
               acc_in = word;
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd3) begin
                  len_in   = word;
                  cnt_in   = 3'd0;
                  acc_in   = '0;
                  phase_in = phase_ff + 3'd1;
               end
            end
            pcsc_pkg::PH_IHDR_TYPE: begin
               acc_in = word;
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd3) begin
                  m_v = 1'b1;
                  if (word == pcsc_pkg::TYPE_IHDR) begin
                     m_res    = pcsc_pkg::mk_result(pcsc_pkg::ST_IHDR_GOOD);
                     cnt_in   = 3'd0;
                     acc_in   = '0;
                     skip_in  = len_ff;
                     phase_in = (len_ff != '0) ? pcsc_pkg::PH_DATA : pcsc_pkg::PH_CRC;
                  end else begin
                     m_res    = pcsc_pkg::mk_result(pcsc_pkg::ST_IHDR_BAD);
                     phase_in = pcsc_pkg::PH_DONE;
                  end
               end
            end
            pcsc_pkg::PH_TYPE: begin
               acc_in = word;
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd3) begin
                  is_idat_in = (word == pcsc_pkg::TYPE_IDAT);
                  is_iend_in = (word == pcsc_pkg::TYPE_IEND);
                  if (word != pcsc_pkg::TYPE_IDAT) begin
                     seen_other_in = 1'b1;
                  end
                  cnt_in   = 3'd0;
                  acc_in   = '0;
                  skip_in  = len_ff;
                  phase_in = (len_ff != '0) ? pcsc_pkg::PH_DATA : pcsc_pkg::PH_CRC;
               end
            end
            pcsc_pkg::PH_DATA: begin
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  phase_in = pcsc_pkg::PH_CRC;
               end
            end
            pcsc_pkg::PH_CRC: begin
               acc_in = word;
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd3) begin
                  cnt_in = 3'd0;
                  acc_in = '0;
                  if (is_idat_ff) begin
                     m_v                = 1'b1;
                     m_res              = pcsc_pkg::mk_result(pcsc_pkg::ST_IDAT);
                     m_res.chunk_offset = off_ff;
                     m_res.chunk_length = len_ff;
                     m_res.chunk_crc    = word;
                     seen_idat_in       = 1'b1;
                     phase_in           = pcsc_pkg::PH_LEN;
                  end else if (is_iend_ff) begin
                     m_v      = 1'b1;
                     m_res    = pcsc_pkg::mk_result(seen_idat_ff ? pcsc_pkg::ST_IEND_FOUND
                                                                 : pcsc_pkg::ST_NO_IDAT);
                     phase_in = pcsc_pkg::PH_DONE;
                  end else begin
                     phase_in = pcsc_pkg::PH_LEN;
                  end
               end
            end
            default: begin
            end
         endcase
         pos_in = pos_ff + 32'd1;

         if (item_eos) begin
            if (phase_in <= pcsc_pkg::PH_IHDR_TYPE) begin
               a_v = 1'b1;
            end else if (phase_in != pcsc_pkg::PH_DONE) begin
               a_v   = ~seen_idat_in & seen_other_in;
               a_res = pcsc_pkg::mk_result(pcsc_pkg::ST_NO_IDAT);
               b_v   = 1'b1;
            end
            // rearm for the next file
            phase_in      = pcsc_pkg::PH_SIG;
            pos_in        = '0;
            cnt_in        = '0;
            acc_in        = '0;
            len_in        = '0;
            off_in        = '0;
            skip_in       = '0;
            is_idat_in    = 1'b0;
            is_iend_in    = 1'b0;
            seen_idat_in  = 1'b0;
            seen_other_in = 1'b0;
            mismatch_in   = 1'b0;
         end
      end

      // pack the up to two results into the front slots
      push.push0 = m_v | a_v | b_v;
      push.push1 = (m_v & (a_v | b_v)) | (a_v & b_v);
      push.res0  = m_v ? m_res : (a_v ? a_res : b_res);
      push.res1  = (m_v & a_v) ? a_res : b_res;
      push.res0.last_of_run = ~push.push1;
      push.res1.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= pcsc_pkg::PH_SIG;
         pos_ff        <= '0;
         cnt_ff        <= '0;
         acc_ff        <= '0;
         len_ff        <= '0;
         off_ff        <= '0;
         skip_ff       <= '0;
         is_idat_ff    <= 1'b0;
         is_iend_ff    <= 1'b0;
         seen_idat_ff  <= 1'b0;
         seen_other_ff <= 1'b0;
         mismatch_ff   <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         cnt_ff        <= cnt_in;
         acc_ff        <= acc_in;
         len_ff        <= len_in;
         off_ff        <= off_in;
         skip_ff       <= skip_in;
         is_idat_ff    <= is_idat_in;
         is_iend_ff    <= is_iend_in;
         seen_idat_ff  <= seen_idat_in;
         seen_other_ff <= seen_other_in;
         mismatch_ff   <= mismatch_in;
      end
   end

   a_data_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == pcsc_pkg::PH_DATA && $past(phase_ff) != pcsc_pkg::PH_DATA
      |-> skip_ff != '0)
      else $error("data phase entered with nothing to skip");

   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      item_valid && !item_eos && phase_ff == pcsc_pkg::PH_DONE |-> !push.push0)
      else $error("result produced after the walk finished");

   a_eos_rearm: assert property (@(posedge clock) disable iff (reset)
      item_valid && item_eos |=> phase_ff == pcsc_pkg::PH_SIG && pos_ff == '0)
      else $error("walk not rearmed after end of stream");

endmodule

// ----- rtl/pcsc_res_queue.sv -----
// Result queue: takes up to two results per cycle, hands out one per cycle while rsp_stall is low.
module pcsc_res_queue (
   input  logic               clock,
   input  logic               reset,
   input  pcsc_pkg::push_type push,
   output logic               space_ok,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pcsc_pkg::result_type head
);

   pcsc_pkg::result_type entry_ff [pcsc_pkg::RES_DEPTH];

   logic [pcsc_pkg::RES_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pcsc_pkg::RES_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pcsc_pkg::RES_CNT_W-1:0] count_ff, count_in;
   logic [pcsc_pkg::RES_PTR_W-1:0] wr_next;
   logic                           pop;

   localparam logic [pcsc_pkg::RES_CNT_W-1:0] SpaceLimit =
      pcsc_pkg::RES_CNT_W'(pcsc_pkg::RES_DEPTH - 2);

   assign space_ok  = (count_ff <= SpaceLimit);
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid & ~rsp_stall;
   assign head      = entry_ff[rd_ptr_ff];
   assign wr_next   = wr_ptr_ff + pcsc_pkg::RES_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + pcsc_pkg::RES_PTR_W'(push.push0)
                            + pcsc_pkg::RES_PTR_W'(push.push1);
      rd_ptr_in = rd_ptr_ff + pcsc_pkg::RES_PTR_W'(pop);
      count_in  = count_ff + pcsc_pkg::RES_CNT_W'(push.push0)
                           + pcsc_pkg::RES_CNT_W'(push.push1)
                           - pcsc_pkg::RES_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.push0) begin
         entry_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.push1) begin
         entry_ff[wr_next] <= push.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.push0 |-> count_ff <= SpaceLimit)
      else $error("result queue written without room for two");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push.push1 |-> push.push0)
      else $error("second result slot used without the first");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pcsc_pkg::RES_CNT_W'(pcsc_pkg::RES_DEPTH))
      else $error("result queue count out of range");

endmodule

// ----- rtl/png_chunk_stream_checker_unit.sv -----
// PNG chunk stream checker: signature/IHDR check and IDAT chunk reporting.
//
// Takes one file byte per item and sustains one byte per cycle while the queue has
// room. A byte is held in an input register, runs through the chunk walker once
// the queue has room and lands in a four-entry result queue. A byte may cause up to
// two results; the queue hands out one per cycle while rsp_stall is low, and the
// input register holds its byte (req_stall high) while fewer than two queue entries
// are free. Results come in byte order; the last result caused by a byte carries
// rsp_last_of_run. After a byte marked end_of_stream the walker rearms for a new
// file.
module png_chunk_stream_checker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic [31:0] rsp_chunk_offset,
   output logic [31:0] rsp_chunk_length,
   output logic [31:0] rsp_chunk_crc,
   output logic        rsp_last_of_run
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eos_ff;
   logic       space_ok;
   logic       consume;
   logic       accept;

   pcsc_pkg::push_type   push;
   pcsc_pkg::result_type head;

   assign consume   = in_valid_ff & space_ok;
   assign req_stall = in_valid_ff & ~space_ok;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_data_byte;
         in_eos_ff  <= req_end_of_stream;
      end
   end

   pcsc_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (consume),
      .item_byte  (in_byte_ff),
      .item_eos   (in_eos_ff),
      .push       (push)
   );

   pcsc_res_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_status       = head.status;
   assign rsp_chunk_offset = head.chunk_offset;
   assign rsp_chunk_length = head.chunk_length;
   assign rsp_chunk_crc    = head.chunk_crc;
   assign rsp_last_of_run  = head.last_of_run;

   a_held_byte: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !space_ok |=> in_valid_ff && $stable(in_byte_ff)
                                   && $stable(in_eos_ff))
      else $error("held byte lost while the queue was full");

   a_idat_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != pcsc_pkg::ST_IDAT
      |-> rsp_chunk_offset == '0 && rsp_chunk_length == '0 && rsp_chunk_crc == '0)
      else $error("chunk fields set on a non-IDAT result");

   a_accept_empty: assert property (@(posedge clock) disable iff (reset)
      accept |-> !in_valid_ff || consume)
      else $error("input register overwritten");

endmodule

// ----- verif/png_walk_checker.sv -----
`timescale 1ns / 1ps
// Checker for the PNG chunk stream checker unit: predicts reports from accepted bytes.
module png_walk_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [3:0]  rsp_status,
   input  logic [31:0] rsp_chunk_offset,
   input  logic [31:0] rsp_chunk_length,
   input  logic [31:0] rsp_chunk_crc,
   input  logic        rsp_last_of_run,
   output int          mismatch_count,
   output int          reports_outstanding
);

   localparam logic [63:0] PNG_MAGIC = 64'h8950_4E47_0D0A_1A0A;

   // Walker state, mirrors what the unit keeps
   logic [2:0]  phase;
   logic [31:0] position;
   logic [2:0]  field_count;
   logic [31:0] field_word;
   logic [31:0] cur_length;
   logic [31:0] cur_offset;
   logic [31:0] skip_left;
   logic        is_idat;
   logic        is_iend;
   logic        idat_seen;
   logic        other_seen;
   logic        magic_bad;

   pcsc_pkg::result_type report_queue [$];
   int                   errors = 0;

   task automatic clear_walk();
      phase       = pcsc_pkg::PH_SIG;
      position    = '0;
      field_count = '0;
      field_word  = '0;
      cur_length  = '0;
      cur_offset  = '0;
      skip_left   = '0;
      is_idat     = 1'b0;
      is_iend     = 1'b0;
      idat_seen   = 1'b0;
      other_seen  = 1'b0;
      magic_bad   = 1'b0;
   endtask

   task automatic post_report(input logic [3:0] st, input logic [31:0] off,
                              input logic [31:0] len, input logic [31:0] crc);
      pcsc_pkg::result_type r;
      r.status       = st;
      r.chunk_offset = off;
      r.chunk_length = len;
      r.chunk_crc    = crc;
      r.last_of_run  = 1'b0;
      report_queue.push_back(r);
   endtask

   task automatic shift_field(input logic [7:0] b);
      field_word  = {field_word[23:0], b};
      field_count = field_count + 3'd1;
   endtask

   task automatic start_chunk_body();
      field_count = '0;
      field_word  = '0;
      skip_left   = cur_length;
      phase       = (skip_left != '0) ? pcsc_pkg::PH_DATA : pcsc_pkg::PH_CRC;
   endtask

   task automatic walk_png_byte(input logic [7:0] b, input logic eos);
      int                   queued;
      int                   idx;
      logic [31:0]          crc;
      pcsc_pkg::result_type r;
      queued = report_queue.size();
      case (phase)
         pcsc_pkg::PH_SIG: begin
            idx = 8 * (7 - int'(field_count));
            if (b != PNG_MAGIC[idx +: 8]) magic_bad = 1'b1;
            field_count = field_count + 3'd1;
            if (field_count == 3'd0) begin
               post_report(magic_bad ? pcsc_pkg::ST_SIG_BAD : pcsc_pkg::ST_SIG_GOOD,
                           '0, '0, '0);
               phase = magic_bad ? pcsc_pkg::PH_DONE : pcsc_pkg::PH_IHDR_LEN;
            end
         end
         pcsc_pkg::PH_IHDR_LEN, pcsc_pkg::PH_LEN: begin
            if (phase == pcsc_pkg::PH_LEN && field_count == 3'd0) cur_offset = position;
            shift_field(b);
            if (field_count == 3'd4) begin
               cur_length  = field_word;
               field_count = '0;
               field_word  = '0;
               phase       = phase + 3'd1;
            end
         end
         pcsc_pkg::PH_IHDR_TYPE: begin
            shift_field(b);
            if (field_count == 3'd4) begin
               if (field_word == pcsc_pkg::TYPE_IHDR) begin
                  post_report(pcsc_pkg::ST_IHDR_GOOD, '0, '0, '0);
                  start_chunk_body();
               end else begin
                  post_report(pcsc_pkg::ST_IHDR_BAD, '0, '0, '0);
                  phase = pcsc_pkg::PH_DONE;
               end
            end
         end
         pcsc_pkg::PH_TYPE: begin
            shift_field(b);
            if (field_count == 3'd4) begin
               is_idat = (field_word == pcsc_pkg::TYPE_IDAT);
               is_iend = (field_word == pcsc_pkg::TYPE_IEND);
               if (!is_idat) other_seen = 1'b1;
               start_chunk_body();
            end
         end
         pcsc_pkg::PH_DATA: begin
            skip_left = skip_left - 32'd1;
            if (skip_left == '0) phase = pcsc_pkg::PH_CRC;
         end
         pcsc_pkg::PH_CRC: begin
            shift_field(b);
            if (field_count == 3'd4) begin
               crc         = field_word;
               field_count = '0;
               field_word  = '0;
               if (is_idat) begin
                  post_report(pcsc_pkg::ST_IDAT, cur_offset, cur_length, crc);
                  idat_seen = 1'b1;
                  phase     = pcsc_pkg::PH_LEN;
               end else if (is_iend) begin
                  post_report(idat_seen ? pcsc_pkg::ST_IEND_FOUND : pcsc_pkg::ST_NO_IDAT,
                              '0, '0, '0);
                  phase = pcsc_pkg::PH_DONE;
               end else begin
                  phase = pcsc_pkg::PH_LEN;
               end
            end
         end
         default: ;
      endcase
      position = position + 32'd1;

      if (eos) begin
         if (phase <= pcsc_pkg::PH_IHDR_TYPE) begin
            post_report(pcsc_pkg::ST_TRUNCATED, '0, '0, '0);
         end else if (phase != pcsc_pkg::PH_DONE) begin
            if (!idat_seen && other_seen) post_report(pcsc_pkg::ST_NO_IDAT, '0, '0, '0);
            post_report(pcsc_pkg::ST_IEND_MISSING, '0, '0, '0);
         end
         clear_walk();
      end

      // mark the final report of this byte
      if (report_queue.size() > queued) begin
         r = report_queue.pop_back();
         r.last_of_run = 1'b1;
         report_queue.push_back(r);
      end
   endtask

   task automatic check_result();
      pcsc_pkg::result_type want;
      if (report_queue.size() == 0) begin
         if (errors < 10)
            $display("%0t: result with none pending: status %0d offset %h length %h crc %h",
                     $realtime, rsp_status, rsp_chunk_offset, rsp_chunk_length,
                     rsp_chunk_crc);
         errors++;
         return;
      end
      want = report_queue.pop_front();
      if (rsp_status !== want.status || rsp_chunk_offset !== want.chunk_offset ||
          rsp_chunk_length !== want.chunk_length || rsp_chunk_crc !== want.chunk_crc ||
          rsp_last_of_run !== want.last_of_run) begin
         if (errors < 10) begin
            $display("%0t: result mismatch", $realtime);
            $display("   expected status %0d offset %h length %h crc %h last %b",
                     want.status, want.chunk_offset, want.chunk_length, want.chunk_crc,
                     want.last_of_run);
            $display("   actual   status %0d offset %h length %h crc %h last %b",
                     rsp_status, rsp_chunk_offset, rsp_chunk_length, rsp_chunk_crc,
                     rsp_last_of_run);
         end
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_walk();
         report_queue.delete();
      end else begin
         // a result never stems from a byte taken at the same edge
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall) walk_png_byte(req_data_byte, req_end_of_stream);
      end
      mismatch_count      <= errors;
      reports_outstanding <= report_queue.size();
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Testbench top: builds PNG byte streams, drives the unit and gives the verdict.
module testbench;

   localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_end_of_stream;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [3:0]  rsp_status;
   logic [31:0] rsp_chunk_offset;
   logic [31:0] rsp_chunk_length;
   logic [31:0] rsp_chunk_crc;
   logic        rsp_last_of_run;

   int          mismatch_count;
   int          reports_outstanding;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          holdoff_requests = 0;
   int          holdoffs_served = 0;
   int          bytes_sent = 0;
   logic [7:0]  file_bytes [$];

   png_chunk_stream_checker_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_chunk_offset  (rsp_chunk_offset),
      .rsp_chunk_length  (rsp_chunk_length),
      .rsp_chunk_crc     (rsp_chunk_crc),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   png_walk_checker walk_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_end_of_stream   (req_end_of_stream),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_chunk_offset    (rsp_chunk_offset),
      .rsp_chunk_length    (rsp_chunk_length),
      .rsp_chunk_crc       (rsp_chunk_crc),
      .rsp_last_of_run     (rsp_last_of_run),
      .mismatch_count      (mismatch_count),
      .reports_outstanding (reports_outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #2_000_000;
      $display("png_chunk_stream_checker_unit test failed");
      $finish;
   end

   // Receiver: random stalls, plus a long hold-off when asked
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_requests > holdoffs_served) begin
            holdoffs_served++;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_end_of_stream <= eos;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_file();
      for (int i = 0; i < file_bytes.size(); i++)
         send_byte(file_bytes[i], i == file_bytes.size() - 1);
      file_bytes.delete();
   endtask

   task automatic put_word(input logic [31:0] w);
      for (int i = 3; i >= 0; i--) file_bytes.push_back(w[8*i +: 8]);
   endtask

   task automatic put_signature();
      put_word(32'h8950_4E47);
      put_word(32'h0D0A_1A0A);
   endtask

   task automatic put_chunk(input logic [31:0] ctype, input int len);
      put_word(32'(len));
      put_word(ctype);
      repeat (len) file_bytes.push_back(8'($urandom_range(255)));
      put_word($urandom);
   endtask

   // Length, type and a few body bytes of a chunk too long to finish
   task automatic put_endless_chunk(input logic [31:0] ctype);
      put_word($urandom | 32'h8000_0000);
      put_word(ctype);
      repeat ($urandom_range(0, 5)) file_bytes.push_back(8'($urandom_range(255)));
   endtask

   function automatic int pick_length();
      if ($urandom_range(19) == 0) return $urandom_range(100, 300);
      return $urandom_range(0, 8);
   endfunction

   function automatic logic [31:0] pick_chunk_type();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return pcsc_pkg::TYPE_IDAT;
         5, 6:          return TYPE_TEXT;
         7:             return pcsc_pkg::TYPE_IDAT ^ (32'h1 << $urandom_range(31));
         8:             return pcsc_pkg::TYPE_IEND ^ (32'h1 << $urandom_range(31));
         default:       return $urandom;
      endcase
   endfunction

   task automatic build_random_file();
      int          idx;
      int          cut;
      logic [31:0] ihdr_type;
      // raw noise
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 20)) file_bytes.push_back(8'($urandom_range(255)));
         return;
      end
      put_signature();
      if ($urandom_range(15) == 0) begin
         idx = $urandom_range(7);
         file_bytes[idx] = file_bytes[idx] ^ (8'h01 << $urandom_range(7));
      end
      case ($urandom_range(15))
         0:       ihdr_type = pcsc_pkg::TYPE_IHDR ^ (32'h1 << $urandom_range(31));
         1:       ihdr_type = $urandom;
         default: ihdr_type = pcsc_pkg::TYPE_IHDR;
      endcase
      if ($urandom_range(19) == 0) begin
         put_endless_chunk(ihdr_type);
         return;
      end
      put_chunk(ihdr_type, $urandom_range(0, 13));
      repeat ($urandom_range(0, 4)) put_chunk(pick_chunk_type(), pick_length());
      if ($urandom_range(14) == 0) begin
         put_endless_chunk(pick_chunk_type());
         return;
      end
      if ($urandom_range(9) < 7)
         put_chunk(pcsc_pkg::TYPE_IEND,
                   ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
      // trailing bytes after the walk ends
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(1, 6)) file_bytes.push_back(8'($urandom_range(255)));
      if ($urandom_range(4) == 0) begin
         cut = $urandom_range(1, file_bytes.size());
         while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end
   endtask

   task automatic send_random_files(input int count);
      int target;
      target = bytes_sent + count;
      while (bytes_sent < target) begin
         build_random_file();
         send_file();
      end
   endtask

   // Hold the sender until every pending report has come out
   task automatic drain();
      req_valid <= 1'b0;
      repeat (3) @(posedge clock);
      while (reports_outstanding != 0) @(posedge clock);
   endtask

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_data_byte     <= 8'h00;
      req_end_of_stream <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // lone byte: stream ends before any verdict
      file_bytes.push_back(8'h00);
      send_file();
      // signature ends on the final byte: verdict then truncation
      put_signature();
      send_file();
      // small complete file with image data
      put_signature();
      put_chunk(pcsc_pkg::TYPE_IHDR, 2);
      put_chunk(pcsc_pkg::TYPE_IDAT, 3);
      put_chunk(pcsc_pkg::TYPE_IEND, 0);
      send_file();
      // zero-length chunks, IEND without image data
      put_signature();
      put_chunk(pcsc_pkg::TYPE_IHDR, 0);
      put_chunk(TYPE_TEXT, 0);
      put_chunk(pcsc_pkg::TYPE_IEND, 0);
      send_file();
      // stream ends inside the walk after a non-IDAT chunk
      put_signature();
      put_chunk(pcsc_pkg::TYPE_IHDR, 0);
      put_chunk(TYPE_TEXT, 1);
      file_bytes.push_back(8'hFF);
      send_file();
      // wrong first chunk type, rest ignored
      put_signature();
      put_chunk(pcsc_pkg::TYPE_IDAT, 0);
      send_file();
      // bad signature of all-ones bytes
      repeat (9) file_bytes.push_back(8'hFF);
      send_file();
      drain();

      send_idle_pct = 13;
      recv_idle_pct = 80;
      send_random_files(400);
      drain();

      send_idle_pct = 80;
      recv_idle_pct = 13;
      send_random_files(400);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      holdoff_requests = 1;
      send_random_files(400);
      drain();

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && reports_outstanding == 0)
         $display("png_chunk_stream_checker_unit test passed");
      else
         $display("png_chunk_stream_checker_unit test failed");
      $finish;
   end

endmodule
